/* rtl/tcqa_pkg.sv */
// Shared types, codes and constants of the two-class job queue.
package tcqa_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam int REQ_W      = 2;
    localparam int ID_W       = 16;
    localparam int ST_W       = 3;
    localparam int AGE_W      = 16;
    localparam int RUN_W      = 8;
    localparam int STAMP_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = AGE_W'(5);
    localparam logic [RUN_W-1:0] RUN_LIMIT_RST = RUN_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = CFG_IDX_W'(1);

    localparam logic [REQ_W-1:0] REQ_ENQUEUE = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = REQ_W'(1);

    typedef enum logic [ST_W-1:0] {
        ST_ENQUEUED  = 3'd0,
        ST_DELIVERED = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_TICK      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2
    } t_state;

    typedef struct packed {
        logic do_enqueue;
        logic do_full;
        logic do_empty;
        logic do_tick;
        logic scan_start;
        logic scan_step;
        logic pick;
        logic shift_step;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             empty;
        logic             full;
        logic             scan_done;
        logic             shift_done;
    } t_sts;

endpackage

/* rtl/tcqa_ctrl.sv */
// Controller state machine of the two-class job queue.
module tcqa_ctrl
    import tcqa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_sts.req_type == REQ_DEQUEUE && !i_sts.empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    case (i_sts.req_type)
                        REQ_ENQUEUE: begin
                            o_cmd.do_full    = i_sts.full;
                            o_cmd.do_enqueue = !i_sts.full;
                        end
                        REQ_DEQUEUE: begin
                            o_cmd.do_empty   = i_sts.empty;
                            o_cmd.scan_start = !i_sts.empty;
                        end
                        default: o_cmd.do_tick = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.pick      = i_sts.scan_done;
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

/* rtl/tcqa_dpath.sv */
// Datapath of the two-class job queue: entry memory, scan, pick and gap closing.
module tcqa_dpath
    import tcqa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [ID_W-1:0]       i_job_id,
    input  logic                  i_job_priority,
    input  logic                  i_job_is_stop,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_result_valid,
    output logic [ST_W-1:0]       o_status,
    output logic [ID_W-1:0]       o_out_job_id,
    output logic                  o_out_priority,
    output logic                  o_out_is_stop
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = STAMP_W + 2 + TAG_WIDTH;

    // entry word: {stamp, stop, class, tag}
    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic          r_rd_vld;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_ptr;

    logic [CW-1:0]      r_fill;
    logic [STAMP_W-1:0] r_now;
    logic [RUN_W-1:0]   r_run;
    logic [AGE_W-1:0]   r_age_limit;
    logic [RUN_W-1:0]   r_run_limit;

    logic                 r_head_stop;
    logic [TAG_WIDTH-1:0] r_head_tag;
    logic                 r_head_class;
    logic                 r_free_found;
    logic [AW-1:0]        r_free_pos;
    logic [TAG_WIDTH-1:0] r_free_tag;
    logic                 r_free_stop;
    logic [STAMP_W-1:0]   r_free_stamp;
    logic                 r_prem_found;
    logic [AW-1:0]        r_prem_pos;
    logic [TAG_WIDTH-1:0] r_prem_tag;
    logic                 r_prem_stop;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [TAG_WIDTH-1:0] r_out_tag;
    logic                 r_out_class;
    logic                 r_out_stop;

    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [31:0]          id_ext;
    logic [31:0]          tag_ext;
    logic [TAG_WIDTH-1:0] in_tag;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic                 rd_class;
    logic                 rd_stop;
    logic [STAMP_W-1:0]   rd_stamp;
    logic [STAMP_W-1:0]   wait_ticks;
    logic                 age_ok;
    logic [AW-1:0]        pick_pos;
    logic [TAG_WIDTH-1:0] pick_tag;
    logic                 pick_class;
    logic                 pick_stop;
    logic [RUN_W-1:0]     pick_run;

    assign id_ext   = 32'(i_job_id);
    assign in_tag   = id_ext[TAG_WIDTH-1:0];
    assign rd_tag   = r_rd_data[TAG_WIDTH-1:0];
    assign rd_class = r_rd_data[TAG_WIDTH];
    assign rd_stop  = r_rd_data[TAG_WIDTH+1];
    assign rd_stamp = r_rd_data[EW-1:TAG_WIDTH+2];
    assign tag_ext  = 32'(r_out_tag);

    assign o_sts.req_type   = i_req_type;
    assign o_sts.empty      = (r_fill == '0);
    assign o_sts.full       = (r_fill == CW'(QUEUE_DEPTH));
    assign o_sts.scan_done  = (r_ptr >= r_fill) && !r_rd_vld;
    assign o_sts.shift_done = (r_ptr > r_fill) && !r_rd_vld;

    assign rd_en = (i_cmd.scan_step && (r_ptr < r_fill)) ||
                   (i_cmd.shift_step && (r_ptr <= r_fill));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill[AW-1:0];
        wr_data = {r_now, i_job_is_stop, i_job_priority, in_tag};
        if (i_cmd.do_enqueue) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_step && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_rd_idx - CW'(1));
            wr_data = r_rd_data;
        end
    end

    // pick the entry to deliver once the scan has seen every entry
    assign wait_ticks = r_now - r_free_stamp;
    assign age_ok     = r_free_found && (wait_ticks >= STAMP_W'(r_age_limit));

    always_comb begin
        pick_pos   = '0;
        pick_tag   = r_head_tag;
        pick_class = r_head_class;
        pick_stop  = r_head_stop;
        pick_run   = r_run;
        if (r_head_stop) begin
            pick_run = r_run;
        end else if (age_ok) begin
            pick_pos   = r_free_pos;
            pick_tag   = r_free_tag;
            pick_class = 1'b0;
            pick_stop  = r_free_stop;
        end else if ((r_run < r_run_limit) && r_prem_found) begin
            pick_pos   = r_prem_pos;
            pick_tag   = r_prem_tag;
            pick_class = 1'b1;
            pick_stop  = r_prem_stop;
            pick_run   = r_run + RUN_W'(1);
        end else begin
            pick_run = '0;
            if (r_free_found) begin
                pick_pos   = r_free_pos;
                pick_tag   = r_free_tag;
                pick_class = 1'b0;
                pick_stop  = r_free_stop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_now       <= '0;
            r_run       <= '0;
            r_age_limit <= AGE_LIMIT_RST;
            r_run_limit <= RUN_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= rd_en;
            r_out_valid <= i_cmd.do_enqueue | i_cmd.do_full | i_cmd.do_empty |
                           i_cmd.do_tick | i_cmd.pick;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_AGE_LIMIT: r_age_limit <= i_cfg_data[AGE_W-1:0];
                    CFG_RUN_LIMIT: r_run_limit <= i_cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.do_enqueue) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.do_tick) begin
                r_now <= r_now + STAMP_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_ptr <= '0;
            end else if (i_cmd.pick) begin
                r_ptr  <= CW'(pick_pos) + CW'(1);
                r_fill <= r_fill - CW'(1);
                r_run  <= pick_run;
            end else if (rd_en) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= r_ptr;
        end
        if (i_cmd.scan_start) begin
            r_free_found <= 1'b0;
            r_prem_found <= 1'b0;
        end else if (i_cmd.scan_step && r_rd_vld) begin
            if (r_rd_idx == '0) begin
                r_head_tag   <= rd_tag;
                r_head_class <= rd_class;
                r_head_stop  <= rd_stop;
            end
            if (!r_free_found && !rd_class) begin
                r_free_found <= 1'b1;
                r_free_pos   <= r_rd_idx[AW-1:0];
                r_free_tag   <= rd_tag;
                r_free_stop  <= rd_stop;
                r_free_stamp <= rd_stamp;
            end
            if (!r_prem_found && rd_class) begin
                r_prem_found <= 1'b1;
                r_prem_pos   <= r_rd_idx[AW-1:0];
                r_prem_tag   <= rd_tag;
                r_prem_stop  <= rd_stop;
            end
        end
        // result payload: zero fields unless an entry is delivered
        r_out_tag   <= '0;
        r_out_class <= 1'b0;
        r_out_stop  <= 1'b0;
        if (i_cmd.do_enqueue) begin
            r_out_status <= ST_ENQUEUED;
        end else if (i_cmd.do_full) begin
            r_out_status <= ST_FULL;
        end else if (i_cmd.do_empty) begin
            r_out_status <= ST_EMPTY;
        end else if (i_cmd.do_tick) begin
            r_out_status <= ST_TICK;
        end else if (i_cmd.pick) begin
            r_out_status <= ST_DELIVERED;
            r_out_tag    <= pick_tag;
            r_out_class  <= pick_class;
            r_out_stop   <= pick_stop;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_job_id   = tag_ext[ID_W-1:0];
    assign o_out_priority = r_out_class;
    assign o_out_is_stop  = r_out_stop;

endmodule

/* rtl/two_class_queue_with_aging.sv */
// Top level of the two-class job queue with aging and a premium burst limit.
//
// A request beat is taken at a rising edge with start high and busy low, and
// every request gives exactly one result beat: o_result_valid is high for one
// cycle, the cycle after the request ends. The receiver cannot stall, so take
// each result in the cycle it is shown. Enqueue, tick, empty dequeue and full
// drop keep busy low: a new request may follow in the next cycle. A dequeue
// on a non-empty queue keeps busy high while it scans every entry and then
// closes the gap behind the removed one: the entry memory has one read and one
// write port, so the class scan reads one entry a cycle and closing the gap
// moves one entry a cycle. The result beat of a dequeue appears as the gap
// closing begins. Configuration beats (index 0 age limit, index 1 premium run
// limit; other indexes are ignored) are always accepted; write them only while
// the block is idle.
module two_class_queue_with_aging
    import tcqa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [ID_W-1:0]       i_job_id,
    input  logic                  i_job_priority,
    input  logic                  i_job_is_stop,
    // result channel
    output logic                  o_result_valid,
    output logic [ST_W-1:0]       o_status,
    output logic [ID_W-1:0]       o_out_job_id,
    output logic                  o_out_priority,
    output logic                  o_out_is_stop,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // registers take a beat in any cycle
    assign o_cfg_ready = 1'b1;

    // sequence each request: decode, scan, pick, close the gap
    tcqa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hold entries, time, run count and limits; drive the result beat
    tcqa_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_job_id       (i_job_id),
        .i_job_priority (i_job_priority),
        .i_job_is_stop  (i_job_is_stop),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_out_job_id   (o_out_job_id),
        .o_out_priority (o_out_priority),
        .o_out_is_stop  (o_out_is_stop)
    );

endmodule

/* test/tcqa_checker.sv */
// Checker for the two-class job queue: tracks the queue state and compares every result beat.
module tcqa_checker
    import tcqa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [ID_W-1:0]       i_job_id,
    input  logic                  i_job_priority,
    input  logic                  i_job_is_stop,
    input  logic                  i_result_valid,
    input  logic [ST_W-1:0]       i_status,
    input  logic [ID_W-1:0]       i_out_job_id,
    input  logic                  i_out_priority,
    input  logic                  i_out_is_stop,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic [ID_W-1:0]    tag;
        logic               cls;
        logic               stop;
        logic [STAMP_W-1:0] stamp;
    } t_slot;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] job_id;
        logic            cls;
        logic            stop;
    } t_reply;

    t_slot              slots [DEPTH];
    int                 fill;
    logic [STAMP_W-1:0] now_tick;
    logic [RUN_W-1:0]   premium_streak;
    logic [AGE_W-1:0]   age_lim;
    logic [RUN_W-1:0]   streak_lim;
    t_reply             pending_replies [$];
    int                 mismatches;
    int                 outstanding;

    assign o_fail_count  = mismatches;
    assign o_outstanding = outstanding;

    // first slot holding the class, or fill when there is none
    function automatic int first_of_class(logic cls);
        for (int i = 0; i < fill; i++) begin
            if (slots[i].cls == cls) begin
                return i;
            end
        end
        return fill;
    endfunction

    // take one entry out and close the gap behind it
    function automatic t_reply pull_entry(int pos);
        t_reply r;
        if (pos >= fill) begin
            pos = 0;
        end
        r.status = ST_DELIVERED;
        r.job_id = slots[pos].tag;
        r.cls    = slots[pos].cls;
        r.stop   = slots[pos].stop;
        for (int i = pos; i + 1 < fill; i++) begin
            slots[i] = slots[i + 1];
        end
        fill--;
        return r;
    endfunction

    function automatic t_reply serve_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                             logic cls, logic stop);
        t_reply r;
        int     pos;
        r = '0;
        if (req == REQ_ENQUEUE) begin
            if (fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                slots[fill] = '{tag: id, cls: cls, stop: stop, stamp: now_tick};
                fill++;
                r.status = ST_ENQUEUED;
            end
        end else if (req == REQ_DEQUEUE) begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end else if (slots[0].stop) begin
                r = pull_entry(0);
            end else begin
                pos = first_of_class(1'b0);
                if (pos < fill && STAMP_W'(now_tick - slots[pos].stamp) >= STAMP_W'(age_lim))
                begin
                    // an aged free job jumps ahead, streak untouched
                    r = pull_entry(pos);
                end else if (premium_streak < streak_lim && first_of_class(1'b1) < fill) begin
                    r = pull_entry(first_of_class(1'b1));
                    premium_streak = premium_streak + 1'b1;
                end else begin
                    r = pull_entry(first_of_class(1'b0));
                    premium_streak = '0;
                end
            end
        end else begin
            now_tick = now_tick + 1'b1;
            r.status = ST_TICK;
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply fresh;
        if (!i_rst_n) begin
            fill           = 0;
            now_tick       = '0;
            premium_streak = '0;
            age_lim        = AGE_LIMIT_RST;
            streak_lim     = RUN_LIMIT_RST;
            pending_replies.delete();
        end else begin
            if (i_result_valid) begin
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none, actual status %0d",
                             $time, i_status);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("out_job_id", want.job_id, i_out_job_id);
                    check_field("out_priority", want.cls, i_out_priority);
                    check_field("out_is_stop", want.stop, i_out_is_stop);
                end
            end
            if (i_start && !i_busy) begin
                fresh = serve_request(i_req_type, i_job_id, i_job_priority, i_job_is_stop);
                pending_replies.insert(pending_replies.size(), fresh);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AGE_LIMIT: age_lim    = AGE_W'(i_cfg_data);
                    CFG_RUN_LIMIT: streak_lim = RUN_W'(i_cfg_data);
                    default: ;
                endcase
            end
        end
        outstanding = pending_replies.size();
    end

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

endmodule

/* test/two_class_queue_with_aging_tb.sv */
// Testbench top for the two-class job queue: drives requests and config beats, gives the verdict.
module two_class_queue_with_aging_tb
    import tcqa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // tick requests: both encodings of the upper half count as a tick
    localparam logic [REQ_W-1:0]     REQ_TICK       = REQ_W'(2);
    localparam logic [REQ_W-1:0]     REQ_TICK_ALIAS = REQ_W'(3);
    // an index the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = CFG_IDX_W'(3);

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 241;
    localparam int EPOCH_ITEMS     = 24;
    // room for the longest dequeue, which scans and shifts the whole queue; allow a margin
    localparam int SETTLE_CYCLES   = 2 * QUEUE_DEPTH_DEF + 10;
    localparam int STALL_LIMIT     = 2000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type     = '0;
    logic [ID_W-1:0]       i_job_id       = '0;
    logic                  i_job_priority = 1'b0;
    logic                  i_job_is_stop  = 1'b0;
    logic                  o_result_valid;
    logic [ST_W-1:0]       o_status;
    logic [ID_W-1:0]       o_out_job_id;
    logic                  o_out_priority;
    logic                  o_out_is_stop;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;
    int enq_weight   = 40;
    int deq_weight   = 40;

    always #5 i_clk = ~i_clk;

    two_class_queue_with_aging DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_job_id       (i_job_id),
        .i_job_priority (i_job_priority),
        .i_job_is_stop  (i_job_is_stop),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_out_job_id   (o_out_job_id),
        .o_out_priority (o_out_priority),
        .o_out_is_stop  (o_out_is_stop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tcqa_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req_type     (i_req_type),
        .i_job_id       (i_job_id),
        .i_job_priority (i_job_priority),
        .i_job_is_stop  (i_job_is_stop),
        .i_result_valid (o_result_valid),
        .i_status       (o_status),
        .i_out_job_id   (o_out_job_id),
        .i_out_priority (o_out_priority),
        .i_out_is_stop  (o_out_is_stop),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // Watchdog: any request, result or config beat restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one request beat and hold it until the block takes it. Start is
    // left high on return so back-to-back beats never lower and raise it in
    // one step; the next call or a drain decides what happens to it.
    task automatic send_request(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                                logic cls, logic stop);
        while (gaps_on && $urandom_range(0, 99) < 19) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= kind;
        i_job_id       <= id;
        i_job_priority <= cls;
        i_job_is_stop  <= stop;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start, wait for every awaited result, then let the block go quiet.
    task automatic drain_block(int extra);
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0 || busy);
        repeat (extra) @(posedge i_clk);
    endtask

    // One config beat; valid stays high on return, like start above.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        while (gaps_on && $urandom_range(0, 99) < 19) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic random_request();
        int                roll;
        logic [REQ_W-1:0]  kind;
        roll = $urandom_range(0, 99);
        if (roll < enq_weight) begin
            kind = REQ_ENQUEUE;
        end else if (roll < enq_weight + deq_weight) begin
            kind = REQ_DEQUEUE;
        end else begin
            kind = ($urandom_range(0, 3) == 0) ? REQ_TICK_ALIAS : REQ_TICK;
        end
        // unused fields carry random bits on dequeue and tick beats as well
        send_request(kind, ID_W'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        logic [AGE_W-1:0] age_set [NUM_PHASES];
        logic [RUN_W-1:0] run_set [NUM_PHASES];

        // phase 0 runs on reset values; the rest cover both extremes of each register
        age_set = '{AGE_LIMIT_RST, 16'd0, 16'hFFFF, 16'd3, 16'd1, 16'hFFFF, 16'd10, 16'd0};
        run_set = '{RUN_LIMIT_RST, 8'd0, 8'hFF, 8'd2, 8'hFF, 8'd0, 8'd1, 8'hFF};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, fill to the brim, overflow, both tick codes,
        // then dequeues starting with a stop marker at the head.
        send_request(REQ_DEQUEUE, '0, 1'b0, 1'b0);
        send_request(REQ_ENQUEUE, 16'hFFFF, 1'b1, 1'b1);
        send_request(REQ_ENQUEUE, 16'h0000, 1'b0, 1'b0);
        for (int i = 0; i < 14; i++) begin
            // a stop marker deep in the queue is picked by the class search
            send_request(REQ_ENQUEUE, ID_W'(1) << i, i[0], i == 5);
        end
        send_request(REQ_ENQUEUE, 16'hA5A5, 1'b1, 1'b0);
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_TICK_ALIAS, 16'hFFFF, 1'b1, 1'b1);
        repeat (5) send_request(REQ_DEQUEUE, '0, 1'b0, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain_block(SETTLE_CYCLES);
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CFG_AGE_LIMIT, CFG_DATA_W'(age_set[p]));
                    write_reg(CFG_RUN_LIMIT, CFG_DATA_W'(run_set[p]));
                end else begin
                    write_reg(CFG_RUN_LIMIT, CFG_DATA_W'(run_set[p]));
                    write_reg(CFG_AGE_LIMIT, CFG_DATA_W'(age_set[p]));
                end
                if (p == 4) begin
                    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
                end
                i_cfg_valid <= 1'b0;
            end
            // one phase runs flat out with no gaps
            gaps_on = (p != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // swing between filling and draining so full and empty both show up
                if (n % EPOCH_ITEMS == 0) begin
                    case ($urandom_range(0, 2))
                        0: begin enq_weight = 60; deq_weight = 25; end
                        1: begin enq_weight = 25; deq_weight = 60; end
                        default: begin enq_weight = 40; deq_weight = 40; end
                    endcase
                end
                if ($urandom_range(0, 99) == 0) begin
                    drain_block(0);
                end
                random_request();
            end
        end

        drain_block(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tcqa_pkg.sv
rtl/tcqa_ctrl.sv
rtl/tcqa_dpath.sv
rtl/two_class_queue_with_aging.sv
test/tcqa_checker.sv
test/two_class_queue_with_aging_tb.sv
